// ===== src/crc32_frame_parser_resync_macros.svh =====
// Assertion macros used by the deframer top level.
`ifndef CRC32_FRAME_PARSER_RESYNC_MACROS_SVH
`define CRC32_FRAME_PARSER_RESYNC_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CFRP_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Implication in the same cycle.
`define CFRP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define CFRP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cfrp_pkg.sv =====
// Types, constants and the CRC step shared by the deframer modules.
`timescale 1ns / 1ps
`default_nettype none
package cfrp_pkg;

    localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam int          FRAME_OVERHEAD = 9;
    localparam int          HDR_BYTES      = 5;

    localparam logic [7:0]  SOF_RESET      = 8'hA5;
    localparam logic [7:0]  VER_RESET      = 8'h01;
    localparam logic [8:0]  MAXLEN_RESET   = 9'd503;

    typedef enum logic [1:0] {
        REG_SOF    = 2'd0,
        REG_VER    = 2'd1,
        REG_MAXLEN = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_FRAME   = 2'd1,
        ST_RESYNC  = 2'd2
    } t_status;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
        logic [8:0] read_index;
    } t_item;

    typedef struct packed {
        logic [7:0] sof;
        logic [7:0] ver;
        logic [8:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic full;
    } t_front_stat;

    typedef struct packed {
        logic pop;
        logic busy;
        logic out_busy;
    } t_eng_stat;

    typedef enum logic [4:0] {
        B_IDLE, B_CHK, B_RD,
        B_CRC_A, B_CRC_B, B_WD_A, B_WD_B, B_CMP,
        B_TYP_A, B_TYP_B, B_CP_A, B_CP_B, B_ACC,
        B_RS_NEXT, B_RS_SOF, B_RS_VER, B_RS_L0, B_RS_L1,
        B_CM_CHK, B_CM_A, B_CM_B
    } t_bstate;

    // One byte through the reflected CRC-32, bit by bit.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== src/cfrp_req_if.sv =====
// Request channel: one received byte or one payload read.
`timescale 1ns / 1ps
`default_nettype none
interface cfrp_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;
    logic [8:0] read_index;

    modport source(output valid, func, rx_byte, read_index, input ready);
    modport sink(input valid, func, rx_byte, read_index, output ready);
endinterface
`default_nettype wire

// ===== src/cfrp_rsp_if.sv =====
// Response channel: status, last frame info and read data.
`timescale 1ns / 1ps
`default_nettype none
interface cfrp_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] frame_type;
    logic [8:0] frame_length;
    logic [7:0] read_data;

    modport source(output valid, status, frame_type, frame_length, read_data, input ready);
    modport sink(input valid, status, frame_type, frame_length, read_data, output ready);
endinterface
`default_nettype wire

// ===== src/cfrp_front.sv =====
// Front end: takes requests, decodes the operation, holds them in a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module cfrp_front import cfrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfrp_req_if.sink    i_req,
    output t_item       o_item,
    output logic        o_item_valid,
    input  logic        i_item_pop,
    output t_front_stat o_stat
);
    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_item      w_new;

    // Decode the request into a queue entry
    always_comb begin
        w_new.op         = t_op'(i_req.func);
        w_new.rx_byte    = i_req.rx_byte;
        w_new.read_index = i_req.read_index;
    end

    assign i_req.ready  = (r_cnt != 2'd2);
    assign w_push       = i_req.valid && i_req.ready;
    assign w_pop        = i_item_pop && (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

    // Queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_new;
    end
endmodule
`default_nettype wire

// ===== src/cfrp_engine.sv =====
// Back end: frame buffer, header checks, CRC, resync scan, compaction and payload store.
`timescale 1ns / 1ps
`default_nettype none
module cfrp_engine import cfrp_pkg::*; #(
    parameter int BUFFER_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_item       i_item,
    input  logic        i_item_valid,
    output logic        o_item_pop,
    cfrp_rsp_if.source  o_rsp,
    output t_eng_stat   o_stat
);
    localparam int STORE = BUFFER_BYTES - FRAME_OVERHEAD;
    localparam int AW    = $clog2(BUFFER_BYTES);
    localparam int FW    = $clog2(BUFFER_BYTES + 1);
    localparam int SAW   = $clog2(STORE);

    // Memories
    logic [7:0] r_fbuf  [BUFFER_BYTES];
    logic [7:0] r_store [STORE];
    logic [7:0] r_mem_q;
    logic [7:0] r_st_q;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_wa;
    logic [7:0]    w_mem_wd;
    logic [AW-1:0] w_mem_ra;
    logic           w_st_we;
    logic [SAW-1:0] w_st_wa;
    logic [7:0]     w_st_wd;
    logic [SAW-1:0] w_st_ra;

    t_bstate       r_state,    n_state;
    logic [FW-1:0] r_fill,     n_fill;
    logic [7:0]    r_hver,     n_hver;
    logic [7:0]    r_hlo,      n_hlo;
    logic [7:0]    r_hhi,      n_hhi;
    logic [FW-1:0] r_start,    n_start;
    logic [FW-1:0] r_keep,     n_keep;
    logic [AW-1:0] r_ptr,      n_ptr;
    logic [FW-1:0] r_cnt,      n_cnt;
    logic [FW-1:0] r_dst,      n_dst;
    logic [31:0]   r_crc,      n_crc;
    logic [31:0]   r_word,     n_word;
    logic [8:0]    r_len,      n_len;
    logic [7:0]    r_lo,       n_lo;
    logic [7:0]    r_acc_type, n_acc_type;
    logic          r_resync,   n_resync;
    logic          r_rd_ok,    n_rd_ok;
    logic [7:0]    r_last_type, n_last_type;
    logic [8:0]    r_last_len,  n_last_len;
    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;
    logic [7:0]    r_out_type,  n_out_type;
    logic [8:0]    r_out_len,   n_out_len;
    logic [7:0]    r_out_data,  n_out_data;

    logic          w_pop;
    logic          w_emit;
    t_status       w_emit_status;
    logic [7:0]    w_emit_data;
    logic [15:0]   w_lim;
    logic [15:0]   w_hlen;
    logic [15:0]   w_slen;
    logic [FW-1:0] w_avail;

    assign o_item_pop = (r_state == B_IDLE) && !r_out_valid;
    assign w_pop      = o_item_pop && i_item_valid;
    assign w_lim      = (16'(i_cfg.max_len) < 16'(STORE)) ? 16'(i_cfg.max_len) : 16'(STORE);
    assign w_hlen     = {r_hhi, r_hlo};
    assign w_slen     = {r_mem_q, r_lo};
    assign w_avail    = r_fill - r_start;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.frame_type   = r_out_type;
    assign o_rsp.frame_length = r_out_len;
    assign o_rsp.read_data    = r_out_data;

    assign o_stat.pop      = w_pop;
    assign o_stat.busy     = (r_state != B_IDLE);
    assign o_stat.out_busy = r_out_valid;

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state = r_state;     n_fill = r_fill;       n_hver = r_hver;
        n_hlo = r_hlo;         n_hhi = r_hhi;         n_start = r_start;
        n_keep = r_keep;       n_ptr = r_ptr;         n_cnt = r_cnt;
        n_dst = r_dst;         n_crc = r_crc;         n_word = r_word;
        n_len = r_len;         n_lo = r_lo;           n_acc_type = r_acc_type;
        n_resync = r_resync;   n_rd_ok = r_rd_ok;
        n_last_type = r_last_type;  n_last_len = r_last_len;
        n_out_valid = r_out_valid;  n_out_status = r_out_status;
        n_out_type = r_out_type;    n_out_len = r_out_len;
        n_out_data = r_out_data;
        w_emit = 1'b0;  w_emit_status = ST_PENDING;  w_emit_data = 8'd0;
        w_mem_we = 1'b0;  w_mem_wa = '0;  w_mem_wd = 8'd0;  w_mem_ra = '0;
        w_st_we = 1'b0;   w_st_wa = '0;   w_st_wd = 8'd0;   w_st_ra = '0;

        if (o_rsp.valid && o_rsp.ready) n_out_valid = 1'b0;

        case (r_state)
            B_IDLE: begin
                if (w_pop) begin
                    if (i_item.op == OP_READ) begin
                        w_st_ra = SAW'(i_item.read_index);
                        n_rd_ok = (32'(i_item.read_index) < STORE);
                        n_state = B_RD;
                    end else if (r_fill == '0 && i_item.rx_byte != i_cfg.sof) begin
                        w_emit = 1'b1;
                    end else if (r_fill == FW'(BUFFER_BYTES)) begin
                        // full buffer: byte dropped, resync
                        n_start = FW'(1);  n_keep = r_fill;  n_resync = 1'b1;
                        n_state = B_RS_NEXT;
                    end else begin
                        w_mem_we = 1'b1;
                        w_mem_wa = AW'(r_fill);
                        w_mem_wd = i_item.rx_byte;
                        n_fill   = r_fill + FW'(1);
                        n_state  = B_CHK;
                    end
                end
            end
            B_RD: begin
                w_emit = 1'b1;
                w_emit_data = r_rd_ok ? r_st_q : 8'd0;
                n_state = B_IDLE;
            end
            B_CHK: begin
                if (r_fill < FW'(HDR_BYTES)) begin
                    w_emit = 1'b1;  n_state = B_IDLE;
                end else if (r_hver != i_cfg.ver || w_hlen > w_lim ||
                             17'(r_fill) > {1'b0, w_hlen} + 17'(FRAME_OVERHEAD)) begin
                    n_start = FW'(1);  n_keep = r_fill;  n_resync = 1'b1;
                    n_state = B_RS_NEXT;
                end else if (17'(r_fill) < {1'b0, w_hlen} + 17'(FRAME_OVERHEAD)) begin
                    w_emit = 1'b1;  n_state = B_IDLE;
                end else begin
                    n_start = '0;  n_resync = 1'b0;  n_len = 9'(w_hlen);
                    n_ptr = AW'(1);  n_cnt = FW'(w_hlen) + FW'(4);  n_crc = CRC_INIT;
                    n_state = B_CRC_A;
                end
            end
            // CRC over version through payload, each byte read in B_CRC_A and folded in B_CRC_B
            B_CRC_A: begin
                w_mem_ra = r_ptr;
                n_state  = B_CRC_B;
            end
            B_CRC_B: begin
                n_crc = crc_byte(r_crc, r_mem_q);
                n_ptr = r_ptr + AW'(1);
                n_cnt = r_cnt - FW'(1);
                if (r_cnt == FW'(1)) begin
                    n_cnt = FW'(4);  n_word = '0;  n_state = B_WD_A;
                end else begin
                    n_state = B_CRC_A;
                end
            end
            // received CRC word, least significant byte first
            B_WD_A: begin
                w_mem_ra = r_ptr;
                n_state  = B_WD_B;
            end
            B_WD_B: begin
                n_word = {r_mem_q, r_word[31:8]};
                n_ptr  = r_ptr + AW'(1);
                n_cnt  = r_cnt - FW'(1);
                n_state = (r_cnt == FW'(1)) ? B_CMP : B_WD_A;
            end
            B_CMP: begin
                if (r_word == ~r_crc) begin
                    n_state = B_TYP_A;
                end else if (r_resync) begin
                    n_start = r_start + FW'(1);  n_state = B_RS_NEXT;
                end else begin
                    n_start = FW'(1);  n_keep = r_fill;  n_resync = 1'b1;
                    n_state = B_RS_NEXT;
                end
            end
            B_TYP_A: begin
                w_mem_ra = AW'(r_start + FW'(2));
                n_state  = B_TYP_B;
            end
            B_TYP_B: begin
                n_acc_type = r_mem_q;
                n_ptr = AW'(r_start + FW'(HDR_BYTES));
                n_dst = '0;
                n_cnt = FW'(r_len);
                n_state = (r_len == 9'd0) ? B_ACC : B_CP_A;
            end
            // payload copy into the store
            B_CP_A: begin
                w_mem_ra = r_ptr;
                n_state  = B_CP_B;
            end
            B_CP_B: begin
                w_st_we = 1'b1;
                w_st_wa = SAW'(r_dst);
                w_st_wd = r_mem_q;
                n_ptr = r_ptr + AW'(1);
                n_dst = r_dst + FW'(1);
                n_cnt = r_cnt - FW'(1);
                n_state = (r_cnt == FW'(1)) ? B_ACC : B_CP_A;
            end
            B_ACC: begin
                n_last_type = r_acc_type;
                n_last_len  = r_len;
                n_fill = '0;
                w_emit = 1'b1;  w_emit_status = ST_FRAME;
                n_state = B_IDLE;
            end
            // resync scan over candidate start positions
            B_RS_NEXT: begin
                if (r_start >= r_fill) begin
                    n_state = B_CM_CHK;
                end else begin
                    w_mem_ra = AW'(r_start);
                    n_state  = B_RS_SOF;
                end
            end
            B_RS_SOF: begin
                if (r_mem_q != i_cfg.sof) begin
                    n_start = r_start + FW'(1);  n_state = B_RS_NEXT;
                end else if (w_avail < FW'(HDR_BYTES)) begin
                    n_keep = r_start;  n_start = r_start + FW'(1);  n_state = B_RS_NEXT;
                end else begin
                    w_mem_ra = AW'(r_start + FW'(1));
                    n_state  = B_RS_VER;
                end
            end
            B_RS_VER: begin
                if (r_mem_q != i_cfg.ver) begin
                    n_start = r_start + FW'(1);  n_state = B_RS_NEXT;
                end else begin
                    w_mem_ra = AW'(r_start + FW'(3));
                    n_state  = B_RS_L0;
                end
            end
            B_RS_L0: begin
                n_lo = r_mem_q;
                w_mem_ra = AW'(r_start + FW'(4));
                n_state  = B_RS_L1;
            end
            B_RS_L1: begin
                if (w_slen > w_lim) begin
                    n_start = r_start + FW'(1);  n_state = B_RS_NEXT;
                end else if (17'(w_avail) < {1'b0, w_slen} + 17'(FRAME_OVERHEAD)) begin
                    n_keep = r_start;  n_start = r_start + FW'(1);  n_state = B_RS_NEXT;
                end else begin
                    n_len = 9'(w_slen);
                    n_ptr = AW'(r_start + FW'(1));
                    n_cnt = FW'(w_slen) + FW'(4);
                    n_crc = CRC_INIT;
                    n_state = B_CRC_A;
                end
            end
            // move the kept tail to the buffer front
            B_CM_CHK: begin
                if (r_keep < r_fill) begin
                    n_ptr = AW'(r_keep);  n_dst = '0;  n_cnt = r_fill - r_keep;
                    n_state = B_CM_A;
                end else begin
                    n_fill = '0;
                    w_emit = 1'b1;  w_emit_status = ST_RESYNC;
                    n_state = B_IDLE;
                end
            end
            B_CM_A: begin
                w_mem_ra = r_ptr;
                n_state  = B_CM_B;
            end
            B_CM_B: begin
                w_mem_we = 1'b1;
                w_mem_wa = AW'(r_dst);
                w_mem_wd = r_mem_q;
                n_ptr = r_ptr + AW'(1);
                n_dst = r_dst + FW'(1);
                n_cnt = r_cnt - FW'(1);
                if (r_cnt == FW'(1)) begin
                    n_fill = r_dst + FW'(1);
                    w_emit = 1'b1;  w_emit_status = ST_RESYNC;
                    n_state = B_IDLE;
                end else begin
                    n_state = B_CM_A;
                end
            end
            default: n_state = B_IDLE;
        endcase

        // header shadow follows every buffer write
        if (w_mem_we) begin
            if (w_mem_wa == AW'(1)) n_hver = w_mem_wd;
            if (w_mem_wa == AW'(3)) n_hlo  = w_mem_wd;
            if (w_mem_wa == AW'(4)) n_hhi  = w_mem_wd;
        end

        // load the response register
        if (w_emit) begin
            n_out_valid  = 1'b1;
            n_out_status = w_emit_status;
            n_out_type   = n_last_type;
            n_out_len    = n_last_len;
            n_out_data   = w_emit_data;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_fill      <= '0;
            r_last_type <= 8'd0;
            r_last_len  <= 9'd0;
            r_out_valid <= 1'b0;
            r_resync    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_last_type <= n_last_type;
            r_last_len  <= n_last_len;
            r_out_valid <= n_out_valid;
            r_resync    <= n_resync;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_hver <= n_hver;   r_hlo <= n_hlo;     r_hhi <= n_hhi;
        r_start <= n_start; r_keep <= n_keep;   r_ptr <= n_ptr;
        r_cnt <= n_cnt;     r_dst <= n_dst;     r_crc <= n_crc;
        r_word <= n_word;   r_len <= n_len;     r_lo <= n_lo;
        r_acc_type <= n_acc_type;  r_rd_ok <= n_rd_ok;
        r_out_status <= n_out_status;  r_out_type <= n_out_type;
        r_out_len <= n_out_len;        r_out_data <= n_out_data;
    end

    // Frame buffer: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_fbuf[w_mem_wa] <= w_mem_wd;
        r_mem_q <= r_fbuf[w_mem_ra];
    end

    // Payload store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_st_we) r_store[w_st_wa] <= w_st_wd;
        r_st_q <= r_store[w_st_ra];
    end
endmodule
`default_nettype wire

// ===== src/crc32_frame_parser_resync.sv =====
// Top level of the SOF/length/CRC-32 deframer with resync.
// i_req carries requests: func 0 pushes rx_byte, func 1 reads payload byte read_index.
// o_rsp returns exactly one response per request: status (0 pending or read done,
// 1 frame accepted, 2 resync without a frame), type and length of the last frame,
// and read data. Both channels use valid/ready; the APB port sets SOF value,
// version value and maximum payload length (byte addresses 0, 4, 8).
// A two-entry request queue sits in front of the frame engine, so requests are taken
// while the engine works or while a response waits for o_rsp.ready.
// The byte that completes a frame runs a CRC pass over version through payload, reads
// the CRC word and copies the payload, all through the single frame buffer read port.
// A resync reads each scanned position, runs a CRC pass per complete candidate, and
// moves each kept byte of the tail to the buffer front.
// The engine takes the next request only when its response register is empty;
// a stalled receiver therefore backs up into the queue and then into i_req.ready.
// Reset empties the buffer, clears last type and length and reloads the registers;
// buffer and payload store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "crc32_frame_parser_resync_macros.svh"
module crc32_frame_parser_resync import cfrp_pkg::*; #(
    parameter int BUFFER_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfrp_req_if.sink    i_req,
    cfrp_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int STORE_BYTES = BUFFER_BYTES - FRAME_OVERHEAD;

    logic [7:0]  r_sof;
    logic [7:0]  r_ver;
    logic [8:0]  r_max_len;
    t_cfg        w_cfg;
    t_reg_idx    w_idx;
    logic        w_wr;
    t_item       w_item;
    logic        w_item_valid;
    logic        w_item_pop;
    t_front_stat w_front_stat;
    t_eng_stat   w_eng_stat;

    // Configuration registers
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sof     <= SOF_RESET;
            r_ver     <= VER_RESET;
            r_max_len <= MAXLEN_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_SOF:    r_sof     <= pwdata[7:0];
                REG_VER:    r_ver     <= pwdata[7:0];
                REG_MAXLEN: r_max_len <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SOF:    prdata = {24'd0, r_sof};
            REG_VER:    prdata = {24'd0, r_ver};
            REG_MAXLEN: prdata = {23'd0, r_max_len};
            default:    prdata = 32'd0;
        endcase
    end

    assign w_cfg.sof     = r_sof;
    assign w_cfg.ver     = r_ver;
    assign w_cfg.max_len = r_max_len;

    cfrp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop),
        .o_stat       (w_front_stat)
    );

    cfrp_engine #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_pop   (w_item_pop),
        .o_rsp        (o_rsp),
        .o_stat       (w_eng_stat)
    );

    // Checks
    `CFRP_ASSERT_IMP(a_pop_slot, w_eng_stat.pop, !w_eng_stat.out_busy, "request taken over a full response register")
    `CFRP_ASSERT_NXT(a_pop_busy, w_eng_stat.pop, w_eng_stat.busy || w_eng_stat.out_busy, "request taken but dropped")
    `CFRP_ASSERT_NOW(a_queue, !(w_front_stat.empty && w_front_stat.full), "queue both empty and full")
    `CFRP_ASSERT_IMP(a_len, o_rsp.valid, 32'(o_rsp.frame_length) <= STORE_BYTES, "frame length beyond store")
endmodule
`default_nettype wire

// ===== dv/crc32_frame_parser_resync_tb.sv =====
// Self-checking testbench for the SOF/length/CRC-32 deframer with resync.
`timescale 1ns / 1ps
module crc32_frame_parser_resync_tb;
    import cfrp_pkg::*;

    localparam int BUF_BYTES   = 512;
    localparam int STORE_BYTES = BUF_BYTES - FRAME_OVERHEAD;
    localparam int IDLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        t_status    st;
        logic [7:0] ftype;
        logic [8:0] flen;
        logic [7:0] rdata;
    } t_rsp_exp;

    typedef struct {
        bit       typed;
        t_rsp_exp rsp;
    } t_side;

    typedef struct {
        t_op        op;
        logic [7:0] b;
        logic [8:0] idx;
        bit         typed;
        t_status    st;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cfrp_req_if req();
    cfrp_rsp_if rsp();

    crc32_frame_parser_resync dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Deframer shadow state
    logic [7:0] rx_buf [BUF_BYTES];
    int         rx_fill;
    logic [7:0] pay_store [STORE_BYTES];
    bit         pay_written [STORE_BYTES];
    logic [7:0] last_ftype;
    logic [8:0] last_flen;
    logic [7:0] cur_sof, cur_ver;
    logic [8:0] cur_maxlen;

    t_rsp_exp rsp_q[$];
    t_side    side_q[$];
    int       n_err, n_req, n_frames, n_resyncs, n_cfg;
    bit       gaps_on, hold_req, req_hi;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        c = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
        return c;
    endfunction

    function automatic int len_cap();
        return (cur_maxlen < STORE_BYTES) ? int'(cur_maxlen) : STORE_BYTES;
    endfunction

    function automatic int buf_len(int pos);
        return int'(rx_buf[pos % BUF_BYTES]) | (int'(rx_buf[(pos + 1) % BUF_BYTES]) << 8);
    endfunction

    // CRC check of a complete candidate; on a match latch type/length and copy payload
    function automatic bit frame_take(int start, int len);
        logic [31:0] c, w;
        c = CRC_INIT;
        w = '0;
        for (int i = 0; i < len + 4; i++) c = crc_step(c, rx_buf[(start + 1 + i) % BUF_BYTES]);
        for (int i = 0; i < 4; i++) w[8*i +: 8] = rx_buf[(start + 5 + len + i) % BUF_BYTES];
        if (w != ~c) return 1'b0;
        last_ftype = rx_buf[(start + 2) % BUF_BYTES];
        last_flen  = len[8:0];
        for (int i = 0; i < len; i++) begin
            pay_store[i]   = rx_buf[(start + 5 + i) % BUF_BYTES];
            pay_written[i] = 1'b1;
        end
        rx_fill = 0;
        return 1'b1;
    endfunction

    // Scan for a later SOF that starts a complete valid frame, else keep the tail
    function automatic t_status resync_scan();
        int keep, avail, len;
        keep = rx_fill;
        for (int s = 1; s < rx_fill; s++) begin
            if (rx_buf[s] != cur_sof) continue;
            avail = rx_fill - s;
            if (avail < HDR_BYTES) begin
                keep = s;
                continue;
            end
            if (rx_buf[s + 1] != cur_ver) continue;
            len = buf_len(s + 3);
            if (len > len_cap()) continue;
            if (avail < len + FRAME_OVERHEAD) begin
                keep = s;
                continue;
            end
            if (frame_take(s, len)) return ST_FRAME;
        end
        if (keep < rx_fill) begin
            for (int i = 0; i < rx_fill - keep; i++) rx_buf[i] = rx_buf[keep + i];
            rx_fill = rx_fill - keep;
        end else begin
            rx_fill = 0;
        end
        return ST_RESYNC;
    endfunction

    function automatic t_status rx_push(logic [7:0] b);
        int len;
        if (rx_fill == 0 && b != cur_sof) return ST_PENDING;
        if (rx_fill >= BUF_BYTES) return resync_scan();
        rx_buf[rx_fill] = b;
        rx_fill++;
        if (rx_fill < HDR_BYTES) return ST_PENDING;
        if (rx_buf[1] != cur_ver) return resync_scan();
        len = buf_len(3);
        if (len > len_cap()) return resync_scan();
        if (rx_fill < len + FRAME_OVERHEAD) return ST_PENDING;
        if (rx_fill != len + FRAME_OVERHEAD) return resync_scan();
        if (frame_take(0, len)) return ST_FRAME;
        return resync_scan();
    endfunction

    function automatic t_rsp_exp deframe_predict(t_op op, logic [7:0] b, logic [8:0] idx);
        t_rsp_exp r;
        r.rdata = '0;
        if (op == OP_PUSH) begin
            r.st = rx_push(b);
        end else begin
            r.st = ST_PENDING;
            if (idx < STORE_BYTES) r.rdata = pay_store[idx];
        end
        r.ftype = last_ftype;
        r.flen  = last_flen;
        return r;
    endfunction

    // Predict at each accepted request
    always @(posedge i_clk) begin
        t_rsp_exp p;
        t_side    sd;
        if (i_rst_n && req.valid && req.ready) begin
            p  = deframe_predict(t_op'(req.func), req.rx_byte, req.read_index);
            sd = side_q.pop_front();
            if (p.st == ST_FRAME) n_frames++;
            if (p.st == ST_RESYNC) n_resyncs++;
            rsp_q.push_back(sd.typed ? sd.rsp : p);
        end
    end

    // Response sink: random stalls, one long hold-off on request
    initial begin
        int g;
        t_rsp_exp e;
        rsp.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                g = HOLD_CYCLES;
            end else begin
                g = gaps_on ? $urandom_range(0, 11) : 0;
            end
            if (g > 0) begin
                rsp.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp.valid && rsp.ready));
            if (rsp_q.size() == 0) begin
                n_err++;
                $display("%0t: response with no request outstanding: status %0d", $realtime,
                         rsp.status);
            end else begin
                e = rsp_q.pop_front();
                if (rsp.status !== e.st || rsp.frame_type !== e.ftype ||
                    rsp.frame_length !== e.flen || rsp.read_data !== e.rdata) begin
                    n_err++;
                    $display("%0t: mismatch exp st=%0d type=%h len=%0d data=%h",
                             $realtime, e.st, e.ftype, e.flen, e.rdata);
                    $display("%0t:          got st=%0d type=%h len=%0d data=%h",
                             $realtime, rsp.status, rsp.frame_type, rsp.frame_length,
                             rsp.read_data);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // One request; valid stays high across back-to-back requests
    task automatic send_req(t_op op, logic [7:0] b, logic [8:0] idx, bit typed, t_rsp_exp e);
        int g;
        t_side sd;
        sd.typed = typed;
        sd.rsp   = e;
        side_q.push_back(sd);
        req.valid      <= 1'b1;
        req.func       <= op;
        req.rx_byte    <= b;
        req.read_index <= idx;
        req_hi = 1'b1;
        do @(posedge i_clk); while (!req.ready);
        n_req++;
        g = gaps_on ? $urandom_range(0, 11) : 0;
        if (g > 0) begin
            req.valid <= 1'b0;
            req_hi = 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic push_rx(logic [7:0] b);
        t_rsp_exp e;
        e = '{ST_PENDING, 8'h00, 9'd0, 8'h00};
        send_req(OP_PUSH, b, 9'($urandom_range(0, 511)), 1'b0, e);
    endtask

    // Payload read, never of a store entry that was never written
    task automatic read_pay(int idx);
        t_rsp_exp e;
        e = '{ST_PENDING, 8'h00, 9'd0, 8'h00};
        if (idx < STORE_BYTES && !pay_written[idx]) idx = $urandom_range(STORE_BYTES, 511);
        send_req(OP_READ, 8'($urandom_range(0, 255)), idx[8:0], 1'b0, e);
    endtask

    // Wait until every response is back and the engine has settled
    task automatic drain();
        if (req_hi) begin
            req.valid <= 1'b0;
            req_hi = 1'b0;
            @(posedge i_clk);
        end
        while (rsp_q.size() != 0 || side_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Register write with read-back
    task automatic reg_write(t_reg_idx r, logic [8:0] v);
        logic [31:0] want;
        case (r)
            REG_SOF: begin
                cur_sof = v[7:0];
                want = {24'd0, v[7:0]};
            end
            REG_VER: begin
                cur_ver = v[7:0];
                want = {24'd0, v[7:0]};
            end
            default: begin
                cur_maxlen = v;
                want = {23'd0, v};
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {$urandom_range(0, 255) & 32'hFFFF_FE00} | want;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            n_err++;
            $display("%0t: register %0d read exp %h got %h", $realtime, r, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        n_cfg++;
    endtask

    task automatic set_regs(logic [7:0] s, logic [7:0] v, logic [8:0] m);
        reg_write(REG_SOF, {1'b0, s});
        reg_write(REG_VER, {1'b0, v});
        reg_write(REG_MAXLEN, m);
    endtask

    // Build a frame: kind 0 good, 1 bad CRC, 2 bad version, 3 oversize, 4 nested, 5 cut short
    task automatic send_frame(int kind, int len, logic [7:0] ftype);
        logic [7:0]  fb[$];
        logic [7:0]  inner[$];
        logic [31:0] c;
        int          cap, lf;
        cap = len_cap();
        lf  = len;
        if (kind == 3) lf = $urandom_range(cap + 1, 65535);
        if (kind == 4) begin
            for (int i = 0; i < 4; i++) inner.push_back(8'($urandom_range(0, 255)));
            c = CRC_INIT;
            inner.push_front(8'h00);
            inner.push_front(8'h04);
            inner.push_front(8'($urandom_range(0, 255)));
            inner.push_front(cur_ver);
            foreach (inner[i]) c = crc_step(c, inner[i]);
            c = ~c;
            for (int i = 0; i < 4; i++) inner.push_back(c[8*i +: 8]);
            inner.push_front(cur_sof);
            lf = inner.size() + $urandom_range(0, 3);
            if (lf > cap) begin
                kind = 0;
                lf = len;
            end
        end
        fb.push_back(kind == 2 ? cur_ver ^ (8'h01 << $urandom_range(0, 7)) : cur_ver);
        fb.push_back(ftype);
        fb.push_back(lf[7:0]);
        fb.push_back(lf[15:8]);
        if (kind == 4) begin
            foreach (inner[i]) fb.push_back(inner[i]);
            while (fb.size() < lf + 4) fb.push_back(8'($urandom_range(0, 255)));
        end else if (kind != 3) begin
            for (int i = 0; i < lf; i++) fb.push_back(8'($urandom_range(0, 255)));
        end
        c = CRC_INIT;
        foreach (fb[i]) c = crc_step(c, fb[i]);
        c = ~c;
        if (kind == 1 || kind == 4) c[$urandom_range(0, 31)] ^= 1'b1;
        for (int i = 0; i < 4; i++) fb.push_back(c[8*i +: 8]);
        fb.push_front(cur_sof);
        if (kind == 3) fb = fb[0:4];
        if (kind == 5) fb = fb[0:$urandom_range(0, fb.size() - 2)];
        foreach (fb[i]) push_rx(fb[i]);
    endtask

    function automatic int pick_len();
        int cap;
        cap = len_cap();
        if ($urandom_range(0, 24) == 0) return $urandom_range(0, cap);
        return $urandom_range(0, cap < 12 ? cap : 12);
    endfunction

    // Random traffic; well-formed frames are the most common kind
    task automatic random_phase(int n_items);
        int start, k;
        start = n_req;
        while (n_req - start < n_items) begin
            if ($urandom_range(0, 99) < 3) gaps_on = ~gaps_on;
            k = $urandom_range(0, 15);
            if (k < 7) send_frame(0, pick_len(), 8'($urandom_range(0, 255)));
            else if (k == 7) send_frame(1, pick_len(), 8'($urandom_range(0, 255)));
            else if (k == 8) send_frame(2, pick_len(), 8'($urandom_range(0, 255)));
            else if (k == 9) send_frame(3, 0, 8'($urandom_range(0, 255)));
            else if (k == 10) send_frame(4, 0, 8'($urandom_range(0, 255)));
            else if (k == 11) send_frame(5, pick_len(), 8'($urandom_range(0, 255)));
            else if (k == 12) repeat ($urandom_range(1, 4)) push_rx(8'($urandom_range(0, 255)));
            else repeat ($urandom_range(1, 3)) read_pay($urandom_range(0, 511));
        end
    endtask

    // Directed rows with the response typed in where it is obvious
    t_row dir_rows[9] = '{
        '{OP_READ, 8'h00, 9'd503, 1'b1, ST_PENDING},  // read past store after reset
        '{OP_READ, 8'hFF, 9'd511, 1'b1, ST_PENDING},
        '{OP_PUSH, 8'h00, 9'd0,   1'b1, ST_PENDING},  // dropped before SOF
        '{OP_PUSH, 8'hFF, 9'd0,   1'b1, ST_PENDING},
        '{OP_PUSH, 8'hA5, 9'd0,   1'b1, ST_PENDING},  // SOF opens a frame
        '{OP_PUSH, 8'h02, 9'd0,   1'b1, ST_PENDING},  // wrong version
        '{OP_PUSH, 8'h00, 9'd0,   1'b1, ST_PENDING},
        '{OP_PUSH, 8'h00, 9'd0,   1'b1, ST_PENDING},
        '{OP_PUSH, 8'h00, 9'd0,   1'b1, ST_RESYNC}    // header done: resync, nothing found
    };

    // Main sequence
    initial begin
        t_rsp_exp e;
        i_rst_n        <= 1'b0;
        req.valid      <= 1'b0;
        req.func       <= OP_PUSH;
        req.rx_byte    <= '0;
        req.read_index <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        rx_fill = 0;
        last_ftype = '0; last_flen = '0;
        cur_sof = SOF_RESET; cur_ver = VER_RESET; cur_maxlen = MAXLEN_RESET;
        for (int i = 0; i < BUF_BYTES; i++) rx_buf[i] = '0;
        for (int i = 0; i < STORE_BYTES; i++) begin
            pay_store[i] = '0;
            pay_written[i] = 1'b0;
        end
        n_err = 0; n_req = 0; n_frames = 0; n_resyncs = 0; n_cfg = 0;
        gaps_on = 1'b1; hold_req = 1'b0; req_hi = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            e = '{dir_rows[i].st, 8'h00, 9'd0, 8'h00};
            send_req(dir_rows[i].op, dir_rows[i].b, dir_rows[i].idx, dir_rows[i].typed, e);
        end
        send_frame(0, 0, 8'hFF);        // empty payload
        send_frame(0, 3, 8'h00);
        for (int i = 0; i < 3; i++) read_pay(i);
        send_frame(1, 2, 8'h5A);        // CRC mismatch
        send_frame(3, 0, 8'h11);        // oversize length
        send_frame(4, 0, 8'h22);        // valid frame inside a broken one
        drain();

        // Largest payload, then reads at the first and last store index and past the store
        set_regs(SOF_RESET, VER_RESET, 9'd503);
        send_frame(0, STORE_BYTES, 8'hC3);
        read_pay(0);
        read_pay(STORE_BYTES - 1);
        read_pay(511);
        random_phase(50);
        drain();

        set_regs(8'h00, 8'hFF, 9'd0);
        random_phase(40);
        drain();

        set_regs(8'hFF, 8'h00, 9'd300);
        random_phase(30);
        hold_req = 1'b1;
        random_phase(30);
        drain();

        set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 9'($urandom_range(0, 503)));
        random_phase(50);
        drain();

        set_regs(SOF_RESET, VER_RESET, MAXLEN_RESET);
        random_phase(40);
        drain();

        $display("covered %0d requests over %0d register writes", n_req, n_cfg);
        $display("frames accepted %0d, resyncs without a frame %0d", n_frames, n_resyncs);
        if (n_err == 0 && rsp_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
